@@ hdl/rgbyuv_pkg.sv @@
// Shared constants, types and helpers for the RGB to YUV 4:2:0 converter.
`default_nettype none
package rgbyuv_pkg;

   // Frame geometry limits and derived widths
   localparam int MAX_WIDTH   = 4096;
   localparam int MAX_HEIGHT  = 4096;
   localparam int DIM_W       = 13;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int ROW_W       = $clog2(MAX_HEIGHT);
   localparam int STORE_DEPTH = MAX_WIDTH / 2;
   localparam int ADDR_W      = COL_W - 1;

   // Pair sums and block sums
   localparam int PAIR_W  = 9;
   localparam int BLOCK_W = PAIR_W + 1;
   localparam int STORE_W = 3 * PAIR_W;

   // Configuration register indexes
   localparam int CSR_IDX_W = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = CSR_IDX_W'(1);

   localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
   localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

   // BT.601 integer coefficients
   localparam logic [7:0] Y_COEF_R  = 8'd66;
   localparam logic [7:0] Y_COEF_G  = 8'd129;
   localparam logic [7:0] Y_COEF_B  = 8'd25;
   localparam logic [7:0] Y_OFFSET  = 8'd16;
   localparam logic [7:0] ROUND_ADD = 8'd128;
   localparam int         CB_COEF_R = -38;
   localparam int         CB_COEF_G = -74;
   localparam int         CB_COEF_B = 112;
   localparam int         CR_COEF_R = 112;
   localparam int         CR_COEF_G = -94;
   localparam int         CR_COEF_B = -18;
   localparam int         C_BIAS    = 128 + 32768;
   localparam int         BYTE_MAX  = 255;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } rgb_type;

   typedef struct packed {
      logic [PAIR_W-1:0] blue;
      logic [PAIR_W-1:0] green;
      logic [PAIR_W-1:0] red;
   } pair_type;

   typedef struct packed {
      logic [BLOCK_W-1:0] blue;
      logic [BLOCK_W-1:0] green;
      logic [BLOCK_W-1:0] red;
   } block_type;

   // Work held between the input register and the result register
   typedef struct packed {
      rgb_type  pixel;
      pair_type pair;
      logic     chroma;
      logic     last;
   } stage_type;

   typedef struct packed {
      logic [7:0] luma;
      logic [7:0] cb;
      logic [7:0] cr;
   } yuv_type;

   // Clip to the limit, force even, floor at two
   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] limit);
      logic [DIM_W-1:0] d;
      d = (v > limit) ? limit : v;
      d[0] = 1'b0;
      if (d < DIM_W'(2)) d = DIM_W'(2);
      return d;
   endfunction

endpackage
`default_nettype wire

@@ hdl/rgbyuv_if.sv @@
// Channel interfaces: pixel input, YUV result and register write port.
`default_nettype none
interface rgbyuv_pix_if import rgbyuv_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rgbyuv_yuv_if import rgbyuv_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [7:0] luma;
   logic       chroma_valid;
   logic [7:0] chroma_blue;
   logic [7:0] chroma_red;
   logic       frame_last;
   modport source (output valid, output luma, output chroma_valid, output chroma_blue,
                   output chroma_red, output frame_last, input ready);
   modport sink   (input valid, input luma, input chroma_valid, input chroma_blue,
                   input chroma_red, input frame_last, output ready);
endinterface

interface rgbyuv_csr_if import rgbyuv_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [DIM_W-1:0]     data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ hdl/rgbyuv_color_math.sv @@
// BT.601 luma of one pixel and Cb/Cr of one averaged 2x2 block.
`default_nettype none
module rgbyuv_color_math import rgbyuv_pkg::*; (
   input  rgb_type   pixel,
   input  block_type block,
   output yuv_type   yuv
);

   localparam int CW = 18;

   function automatic logic [7:0] clamp_chroma(input logic signed [CW-1:0] t);
      logic signed [CW-1:0] s;
      s = t >>> 8;
      if (t < 0) return 8'd0;
      if (s > CW'(BYTE_MAX)) return 8'(BYTE_MAX);
      return s[7:0];
   endfunction

   logic [16:0]          y_sum;
   logic [8:0]           y_val;
   logic [7:0]           avg_r, avg_g, avg_b;
   logic signed [CW-1:0] sr, sg, sb;
   logic signed [CW-1:0] cb_sum, cr_sum;

   always_comb begin
      y_sum = 17'(Y_COEF_R) * {9'd0, pixel.red} + 17'(Y_COEF_G) * {9'd0, pixel.green}
            + 17'(Y_COEF_B) * {9'd0, pixel.blue} + 17'(ROUND_ADD);
      y_val = y_sum[16:8] + 9'(Y_OFFSET);
      yuv.luma = (y_val > 9'(BYTE_MAX)) ? 8'(BYTE_MAX) : y_val[7:0];

      // Block average: sum of four, shift by two
      avg_r = block.red[BLOCK_W-1:2];
      avg_g = block.green[BLOCK_W-1:2];
      avg_b = block.blue[BLOCK_W-1:2];
      sr = $signed({{(CW-8){1'b0}}, avg_r});
      sg = $signed({{(CW-8){1'b0}}, avg_g});
      sb = $signed({{(CW-8){1'b0}}, avg_b});

      cb_sum = CW'(CB_COEF_R) * sr + CW'(CB_COEF_G) * sg + CW'(CB_COEF_B) * sb
             + CW'(C_BIAS);
      cr_sum = CW'(CR_COEF_R) * sr + CW'(CR_COEF_G) * sg + CW'(CR_COEF_B) * sb
             + CW'(C_BIAS);
      yuv.cb = clamp_chroma(cb_sum);
      yuv.cr = clamp_chroma(cr_sum);
   end

endmodule
`default_nettype wire

@@ hdl/rgb_to_yuv420_converter.sv @@
// Top level: RGB24 raster stream in, BT.601 luma per pixel and 4:2:0 chroma out.
//
//  channel  | dir | payload                                           | transfer
//  ---------+-----+---------------------------------------------------+------------------
//  req_pix  | in  | red, green, blue                                  | valid & ready
//  rsp_yuv  | out | luma, chroma_valid, chroma_blue, chroma_red, last | valid & ready
//  csr_wr   | in  | index, data (frame_width, frame_height)           | valid & ready
//
// One pixel per clock while the result is not stalled; an input transfer loads the input
// stage and the line store read, then the math result loads the result register.
// The line store is one 2048 x 27 memory with one write and one registered read.
// Synchronous reset clears counters, held pixel and valid flags; the store is not
// cleared, since each entry is written on an even row before the odd row reads it.
// A stalled result holds; the input stage takes one more pixel, then ready drops.
`default_nettype none
module rgb_to_yuv420_converter import rgbyuv_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   rgbyuv_pix_if.sink    req_pix,
   rgbyuv_yuv_if.source  rsp_yuv,
   rgbyuv_csr_if.sink    csr_wr
);

   logic [DIM_W-1:0] width_ff, height_ff;
   logic [DIM_W-1:0] width_eff, height_eff;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   rgb_type          held_ff, held_in;

   stage_type        stage_ff, stage_in;
   logic             stage_valid_ff, stage_valid_in;
   logic [STORE_W-1:0] rd_ff;

   yuv_type          res_ff, res_in;
   logic             res_chroma_ff, res_chroma_in;
   logic             res_last_ff, res_last_in;
   logic             res_valid_ff, res_valid_in;

   logic             accept, csr_write, csr_restart, out_free, stage_adv;
   logic             row_end, frame_end, odd_col, odd_row;
   logic [DIM_W-1:0] col_next, row_next;
   logic [ADDR_W-1:0] addr;
   rgb_type          pixel;
   pair_type         pair;
   pair_type         upper;
   block_type        block;
   yuv_type          math_yuv;

   assign width_eff  = eff_dim(width_ff, DIM_W'(MAX_WIDTH));
   assign height_eff = eff_dim(height_ff, DIM_W'(MAX_HEIGHT));

   assign out_free  = !res_valid_ff || rsp_yuv.ready;
   assign stage_adv = stage_valid_ff && out_free;
   assign req_pix.ready = !stage_valid_ff || out_free;
   assign accept    = req_pix.valid && req_pix.ready;
   assign csr_wr.ready = 1'b1;
   assign csr_write = csr_wr.valid;
   // Only a write to a known register restarts the frame
   assign csr_restart = csr_write && (csr_wr.index == CSR_FRAME_WIDTH ||
                                      csr_wr.index == CSR_FRAME_HEIGHT);

   assign pixel = '{blue: req_pix.blue, green: req_pix.green, red: req_pix.red};
   assign odd_col = col_ff[0];
   assign odd_row = row_ff[0];
   assign addr    = col_ff[COL_W-1:1];

   assign col_next  = {1'b0, col_ff} + DIM_W'(1);
   assign row_next  = {1'b0, row_ff} + DIM_W'(1);
   assign row_end   = col_next >= width_eff;
   assign frame_end = row_end && (row_next >= height_eff);

   always_comb begin
      pair.red   = {1'b0, pixel.red}   + {1'b0, held_ff.red};
      pair.green = {1'b0, pixel.green} + {1'b0, held_ff.green};
      pair.blue  = {1'b0, pixel.blue}  + {1'b0, held_ff.blue};
   end

   // Frame position and even-column pixel
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      held_in = held_ff;
      if (accept) begin
         if (!odd_col) held_in = pixel;
         if (row_end) begin
            col_in = '0;
            row_in = frame_end ? '0 : row_next[ROW_W-1:0];
         end else begin
            col_in = col_next[COL_W-1:0];
         end
      end
      if (csr_restart) begin
         col_in  = '0;
         row_in  = '0;
         held_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
         held_ff   <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         held_ff <= held_in;
         if (csr_write) begin
            unique case (csr_wr.index)
               CSR_FRAME_WIDTH:  width_ff  <= csr_wr.data;
               CSR_FRAME_HEIGHT: height_ff <= csr_wr.data;
               default: ;
            endcase
         end
      end
   end

   // Line store of even-row pair sums
   logic [STORE_W-1:0] line_mem [STORE_DEPTH];

   always_ff @(posedge clock) begin
      if (accept && odd_col && !odd_row) line_mem[addr] <= pair;
      if (accept && odd_col && odd_row)  rd_ff <= line_mem[addr];
   end

   // Input stage
   always_comb begin
      stage_in.pixel  = pixel;
      stage_in.pair   = pair;
      stage_in.chroma = odd_col && odd_row;
      stage_in.last   = frame_end;
      stage_valid_in  = accept || (stage_valid_ff && !stage_adv);
   end

   always_ff @(posedge clock) begin
      if (reset) stage_valid_ff <= 1'b0;
      else       stage_valid_ff <= stage_valid_in;
      if (accept) stage_ff <= stage_in;
   end

   // Block sums and color math
   assign upper = rd_ff;
   always_comb begin
      block.red   = {1'b0, stage_ff.pair.red}   + {1'b0, upper.red};
      block.green = {1'b0, stage_ff.pair.green} + {1'b0, upper.green};
      block.blue  = {1'b0, stage_ff.pair.blue}  + {1'b0, upper.blue};
   end

   rgbyuv_color_math u_math (
      .pixel (stage_ff.pixel),
      .block (block),
      .yuv   (math_yuv)
   );

   // Result register
   always_comb begin
      res_in.luma   = math_yuv.luma;
      res_in.cb     = stage_ff.chroma ? math_yuv.cb : 8'd0;
      res_in.cr     = stage_ff.chroma ? math_yuv.cr : 8'd0;
      res_chroma_in = stage_ff.chroma;
      res_last_in   = stage_ff.last;
      res_valid_in  = stage_adv || (res_valid_ff && !rsp_yuv.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) res_valid_ff <= 1'b0;
      else       res_valid_ff <= res_valid_in;
      if (stage_adv) begin
         res_ff        <= res_in;
         res_chroma_ff <= res_chroma_in;
         res_last_ff   <= res_last_in;
      end
   end

   assign rsp_yuv.valid        = res_valid_ff;
   assign rsp_yuv.luma         = res_ff.luma;
   assign rsp_yuv.chroma_valid = res_chroma_ff;
   assign rsp_yuv.chroma_blue  = res_ff.cb;
   assign rsp_yuv.chroma_red   = res_ff.cr;
   assign rsp_yuv.frame_last   = res_last_ff;

   // Position stays inside the active frame
   assert property (@(posedge clock) disable iff (reset)
      ({1'b0, col_ff} < width_eff) && ({1'b0, row_ff} < height_eff))
      else $error("frame position outside active area");

   // A frame end transfer wraps the position to the origin
   assert property (@(posedge clock) disable iff (reset)
      accept && frame_end |=> (col_ff == '0) && (row_ff == '0))
      else $error("position did not wrap after last pixel");

   // Chroma only on the odd column of an odd row
   assert property (@(posedge clock) disable iff (reset)
      accept && (!odd_col || !odd_row) |=> !stage_ff.chroma)
      else $error("chroma flagged outside block corner");

endmodule
`default_nettype wire
